// File: sv/msfr_pkg.sv
// Package for the multichannel sync-frame receiver.
// Holds the item codes, field widths, byte masks and the result record.
// No dependencies; msfr_update and the top level import it.
`default_nettype none

package msfr_pkg;

	// Fixed field widths of the word interface.
	localparam int unsigned CH_IN_W  = 2;
	localparam int unsigned RAW_W    = 8;
	localparam int unsigned BYTE_W   = 7;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned LEN_W    = 14;

	// Defaults for the top-level parameters.
	localparam int unsigned CHANNELS_DEF    = 4;
	localparam int unsigned FRAME_BYTES_DEF = 256;

	// Start flag and payload mask of a received byte.
	localparam logic [RAW_W-1:0] START_MASK = 8'h80;
	localparam logic [RAW_W-1:0] BYTE_MASK  = 8'h7F;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// One result word, less its channel number.
	typedef struct packed {
		logic [BYTE_W-1:0] stored_byte;
		logic [POS_W-1:0]  position;
		logic              stored;
		logic              frame_start;
		logic              frame_done;
		logic [LEN_W-1:0]  frame_length;
		logic              dropped_busy;
		logic              dropped_overflow;
	} res_t;

endpackage

`default_nettype wire

// File: sv/msfr_state_mem.sv
// Per-channel state memory: one entry per channel, registered synchronous
// read and forwarding of a write to the same entry.
// Self-contained; widths and depth come in as parameters.
`default_nettype none

module msfr_state_mem #(
	parameter int unsigned DEPTH   = 4,
	parameter int unsigned IDX_W   = 2,
	parameter int unsigned ENTRY_W = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [IDX_W-1:0]   rd_idx,
	output logic      [ENTRY_W-1:0] rd_data,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_idx,
	input  wire logic [ENTRY_W-1:0] wr_data
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   written_q;
	logic [ENTRY_W-1:0] rd_q;

	// An entry never written since reset reads as all zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// A write landing at the same edge as the read of its entry is forwarded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_q <= wr_data;
			end else if (written_q[rd_idx]) begin
				rd_q <= mem[rd_idx];
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// File: sv/msfr_update.sv
// Frame update of one channel entry for one item: position, length,
// completion and drop decisions, and the new entry to write back.
// Depends on msfr_pkg for widths, masks, item codes and the result record.
`default_nettype none

module msfr_update #(
	parameter int unsigned FRAME_BYTES = 256,
	parameter int unsigned PTR_W       = 9
) (
	input  wire logic                          in_range,
	input  wire logic                          operation,
	input  wire logic [msfr_pkg::RAW_W-1:0]    data_byte,
	input  wire logic                          cur_busy,
	input  wire logic [msfr_pkg::LEN_W-1:0]    cur_len,
	input  wire logic [PTR_W-1:0]              cur_ptr,
	output logic                               wr_en,
	output logic                               nxt_busy,
	output logic      [msfr_pkg::LEN_W-1:0]    nxt_len,
	output logic      [PTR_W-1:0]              nxt_ptr,
	output msfr_pkg::res_t                     res
);
	import msfr_pkg::*;

	logic                  start;
	logic [BYTE_W-1:0]     byte_val;
	logic [PTR_W-1:0]      pos;
	logic [PTR_W-1:0]      next;
	logic                  ovf;
	logic                  at_len_hi;
	logic                  at_len_lo;
	logic                  done;
	logic [LEN_W-1:0]      len_new;
	logic [PTR_W+7:0]      pos_ext;
	logic [PTR_W+13:0]     next_cmp;
	logic [PTR_W+13:0]     len_cmp;
	logic                  is_release;

	always_comb begin
		is_release = (op_t'(operation) == OP_RELEASE);
		start      = |(data_byte & START_MASK);
		byte_val   = BYTE_W'(data_byte & BYTE_MASK);
		pos        = start ? '0 : cur_ptr;
		ovf        = (pos >= PTR_W'(FRAME_BYTES));
		next       = pos + PTR_W'(1);
		at_len_hi  = (next == PTR_W'(2));
		at_len_lo  = (next == PTR_W'(3));
		next_cmp   = {14'd0, next};
		len_cmp    = {{PTR_W{1'b0}}, cur_len};
		pos_ext    = {8'd0, pos};

		priority if (at_len_hi) begin
			len_new = {{(LEN_W-BYTE_W){1'b0}}, byte_val};
		end else if (at_len_lo) begin
			len_new = {cur_len[BYTE_W-1:0], byte_val};
		end else begin
			len_new = cur_len;
		end
		done = !at_len_hi && !at_len_lo && (next_cmp == len_cmp);

		wr_en    = 1'b0;
		nxt_busy = 1'b0;
		nxt_len  = '0;
		nxt_ptr  = '0;
		res      = '0;

		if (in_range) begin
			if (is_release) begin
				// Release clears the whole entry.
				wr_en = 1'b1;
			end else begin
				res.stored_byte = byte_val;
				res.frame_start = start;
				if (cur_busy) begin
					res.frame_length = cur_len;
					res.dropped_busy = 1'b1;
				end else if (ovf) begin
					res.frame_length     = cur_len;
					res.dropped_overflow = 1'b1;
				end else begin
					wr_en            = 1'b1;
					nxt_busy         = done;
					nxt_len          = len_new;
					nxt_ptr          = next;
					res.position     = pos_ext[POS_W-1:0];
					res.stored       = 1'b1;
					res.frame_done   = done;
					res.frame_length = len_new;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/multichannel_sync_frame_receiver_unit.sv
// Top level of the multichannel sync-frame receiver.
// Depends on msfr_pkg, msfr_state_mem and msfr_update.
//
// Usage:
// The input channel (in_valid, in_stall, operation, channel, data_byte)
// carries one word per received byte or per release of a channel. The
// output channel (out_valid, out_stall and the result fields) returns
// exactly one result word for every accepted input word, in order.
// A word is taken at a rising edge where valid is high and stall is low.
// The accept edge reads the channel entry from the state memory into the
// update stage; when the word leaves the update stage, the updated entry
// is written back and the output register is loaded, from which the
// result can be taken. Throughput is one word per cycle while out_stall
// is low, set by the single read-modify-write of the state memory;
// back-to-back words on the same channel are served by forwarding the
// write into the read register.
// Reset clears the pipeline valid flags and marks every channel entry as
// unwritten, which reads as zero position, zero length and not busy; no
// clearing pass is needed. When the receiver holds out_stall, the result
// stays in the output register, one more word can enter the update stage,
// and after that in_stall rises until the output moves again.
`default_nettype none

module multichannel_sync_frame_receiver_unit #(
	parameter int unsigned CHANNELS    = msfr_pkg::CHANNELS_DEF,
	parameter int unsigned FRAME_BYTES = msfr_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         operation,
	input  wire logic [msfr_pkg::CH_IN_W-1:0] channel,
	input  wire logic [msfr_pkg::RAW_W-1:0]   data_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [msfr_pkg::CH_IN_W-1:0] out_channel,
	output logic      [msfr_pkg::BYTE_W-1:0]  stored_byte,
	output logic      [msfr_pkg::POS_W-1:0]   position,
	output logic                              stored,
	output logic                              frame_start,
	output logic                              frame_done,
	output logic      [msfr_pkg::LEN_W-1:0]   frame_length,
	output logic                              dropped_busy,
	output logic                              dropped_overflow
);
	import msfr_pkg::*;

	// Entry index width and pointer width, which must hold FRAME_BYTES itself.
	localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned PTR_W   = $clog2(FRAME_BYTES + 1);
	localparam int unsigned ENTRY_W = 1 + LEN_W + PTR_W;

	// Input decode.
	logic                   in_accept;
	logic [IDX_W+1:0]       ch_ext;
	logic [IDX_W-1:0]       in_idx;
	logic                   in_range;

	// Update stage.
	logic                   valid_s1;
	logic                   op_s1;
	logic [CH_IN_W-1:0]     ch_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [RAW_W-1:0]       raw_s1;
	logic                   range_s1;
	logic                   adv_s1;

	// State memory interface.
	logic [ENTRY_W-1:0]     rd_entry;
	logic [ENTRY_W-1:0]     wr_entry;
	logic                   upd_wr;
	logic                   mem_wr;
	logic                   nxt_busy;
	logic [LEN_W-1:0]       nxt_len;
	logic [PTR_W-1:0]       nxt_ptr;
	res_t                   upd_res;

	// Output register.
	logic                   out_valid_q;
	logic [CH_IN_W-1:0]     out_ch_q;
	res_t                   out_res_q;

	// The update stage moves on whenever the output register is free or
	// is being emptied in this cycle; a new word may enter in the same cycle.
	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	assign ch_ext   = {{IDX_W{1'b0}}, channel};
	assign in_idx   = ch_ext[IDX_W-1:0];
	assign in_range = (32'(channel) < CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= operation;
			ch_s1    <= channel;
			idx_s1   <= in_idx;
			raw_s1   <= data_byte;
			range_s1 <= in_range;
		end
	end

	// The entry of the accepted word is read at the accept edge; the write
	// of the word ahead of it, if it targets the same channel, is forwarded.
	msfr_state_mem #(
		.DEPTH   (CHANNELS),
		.IDX_W   (IDX_W),
		.ENTRY_W (ENTRY_W)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept && in_range),
		.rd_idx  (in_idx),
		.rd_data (rd_entry),
		.wr_en   (mem_wr),
		.wr_idx  (idx_s1),
		.wr_data (wr_entry)
	);

	msfr_update #(
		.FRAME_BYTES (FRAME_BYTES),
		.PTR_W       (PTR_W)
	) u_update (
		.in_range  (range_s1),
		.operation (op_s1),
		.data_byte (raw_s1),
		.cur_busy  (rd_entry[ENTRY_W-1]),
		.cur_len   (rd_entry[PTR_W+LEN_W-1:PTR_W]),
		.cur_ptr   (rd_entry[PTR_W-1:0]),
		.wr_en     (upd_wr),
		.nxt_busy  (nxt_busy),
		.nxt_len   (nxt_len),
		.nxt_ptr   (nxt_ptr),
		.res       (upd_res)
	);

	// The entry is written back only when the word leaves the update stage.
	assign mem_wr   = adv_s1 && upd_wr;
	assign wr_entry = {nxt_busy, nxt_len, nxt_ptr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_ch_q  <= ch_s1;
			out_res_q <= upd_res;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_channel      = out_ch_q;
	assign stored_byte      = out_res_q.stored_byte;
	assign position         = out_res_q.position;
	assign stored           = out_res_q.stored;
	assign frame_start      = out_res_q.frame_start;
	assign frame_done       = out_res_q.frame_done;
	assign frame_length     = out_res_q.frame_length;
	assign dropped_busy     = out_res_q.dropped_busy;
	assign dropped_overflow = out_res_q.dropped_overflow;

endmodule

`default_nettype wire
